// File: rtl/tked_pkg.sv
// ----------------------------------------------------------------------------
// tked_pkg: shared types and constants for the terminal key escape decoder
// Input commands, key codes, sequence bytes, phase encoding, result type and
// the final-byte lookup functions.
// ----------------------------------------------------------------------------
package tked_pkg;

    localparam int CmdWidth  = 2;
    localparam int ByteWidth = 8;
    localparam int KeyWidth  = 4;

    // input commands
    localparam logic [CmdWidth-1:0] CMD_BYTE    = 2'd0;
    localparam logic [CmdWidth-1:0] CMD_TIMEOUT = 2'd1;

    // key codes
    localparam logic [KeyWidth-1:0] KEY_PLAIN      = 4'd0;
    localparam logic [KeyWidth-1:0] KEY_ESC        = 4'd1;
    localparam logic [KeyWidth-1:0] KEY_ARROW_UP   = 4'd2;
    localparam logic [KeyWidth-1:0] KEY_ARROW_DN   = 4'd3;
    localparam logic [KeyWidth-1:0] KEY_ARROW_LT   = 4'd4;
    localparam logic [KeyWidth-1:0] KEY_ARROW_RT   = 4'd5;
    localparam logic [KeyWidth-1:0] KEY_LINE_START = 4'd6;
    localparam logic [KeyWidth-1:0] KEY_LINE_END   = 4'd7;
    localparam logic [KeyWidth-1:0] KEY_PAGE_UP    = 4'd8;
    localparam logic [KeyWidth-1:0] KEY_PAGE_DN    = 4'd9;
    localparam logic [KeyWidth-1:0] KEY_DEL        = 4'd10;
    localparam logic [KeyWidth-1:0] KEY_FILETOP    = 4'd11;
    localparam logic [KeyWidth-1:0] KEY_FILEEND    = 4'd12;
    localparam logic [KeyWidth-1:0] KEY_ERROR      = 4'd13;

    // sequence bytes
    localparam logic [ByteWidth-1:0] BYTE_ESC   = 8'h1b;
    localparam logic [ByteWidth-1:0] BYTE_CSI   = 8'h5b;  // '['
    localparam logic [ByteWidth-1:0] BYTE_SS3   = 8'h4f;  // 'O'
    localparam logic [ByteWidth-1:0] BYTE_TILDE = 8'h7e;  // '~'
    localparam logic [ByteWidth-1:0] BYTE_SEMI  = 8'h3b;  // ';'
    localparam logic [ByteWidth-1:0] BYTE_CTRL  = 8'h35;  // '5'
    localparam logic [ByteWidth-1:0] BYTE_ZERO  = 8'h30;  // '0'
    localparam logic [ByteWidth-1:0] BYTE_NINE  = 8'h39;  // '9'
    localparam logic [ByteWidth-1:0] BYTE_A     = 8'h41;
    localparam logic [ByteWidth-1:0] BYTE_B     = 8'h42;
    localparam logic [ByteWidth-1:0] BYTE_C     = 8'h43;
    localparam logic [ByteWidth-1:0] BYTE_D     = 8'h44;
    localparam logic [ByteWidth-1:0] BYTE_F     = 8'h46;
    localparam logic [ByteWidth-1:0] BYTE_H     = 8'h48;
    localparam logic [ByteWidth-1:0] BYTE_1     = 8'h31;
    localparam logic [ByteWidth-1:0] BYTE_3     = 8'h33;
    localparam logic [ByteWidth-1:0] BYTE_4     = 8'h34;
    localparam logic [ByteWidth-1:0] BYTE_6     = 8'h36;
    localparam logic [ByteWidth-1:0] BYTE_7     = 8'h37;
    localparam logic [ByteWidth-1:0] BYTE_8     = 8'h38;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_ESC   = 6'b000010,
        PH_INTRO = 6'b000100,
        PH_DIGIT = 6'b001000,
        PH_SEMI  = 6'b010000,
        PH_MOD   = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        INTRO_CSI   = 2'd0,
        INTRO_SS3   = 2'd1,
        INTRO_OTHER = 2'd2
    } intro_t;

    typedef struct packed {
        logic                 valid;
        logic [KeyWidth-1:0]  key;
        logic [ByteWidth-1:0] plain_byte;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic [CmdWidth-1:0]  cmd;
        logic [ByteWidth-1:0] in_byte;
    } item_t;

    function automatic logic [KeyWidth-1:0] letter_key(input logic [ByteWidth-1:0] b);
        logic [KeyWidth-1:0] k;
        unique case (b)
            BYTE_A:  k = KEY_ARROW_UP;
            BYTE_B:  k = KEY_ARROW_DN;
            BYTE_C:  k = KEY_ARROW_RT;
            BYTE_D:  k = KEY_ARROW_LT;
            BYTE_H:  k = KEY_LINE_START;
            BYTE_F:  k = KEY_LINE_END;
            default: k = KEY_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [KeyWidth-1:0] tilde_key(input logic [ByteWidth-1:0] d);
        logic [KeyWidth-1:0] k;
        unique case (d)
            BYTE_1, BYTE_7: k = KEY_LINE_START;
            BYTE_3:         k = KEY_DEL;
            BYTE_4, BYTE_8: k = KEY_LINE_END;
            BYTE_CTRL:      k = KEY_PAGE_UP;
            BYTE_6:         k = KEY_PAGE_DN;
            default:        k = KEY_ESC;
        endcase
        return k;
    endfunction

    function automatic result_t key_result(input logic [KeyWidth-1:0] k);
        result_t r;
        r.valid      = 1'b1;
        r.key        = k;
        r.plain_byte = (k == KEY_ESC) ? BYTE_ESC : '0;
        return r;
    endfunction

endpackage

// File: rtl/tked_in_stage.sv
// ----------------------------------------------------------------------------
// tked_in_stage: input register
// Captures one event item; frees in the same cycle the decoder consumes it.
// ----------------------------------------------------------------------------
module tked_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tked_pkg::CmdWidth-1:0]   cmd,
    input  logic [tked_pkg::ByteWidth-1:0]  in_byte,
    input  logic                            advance,
    output tked_pkg::item_t                 item
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [tked_pkg::CmdWidth-1:0]  cmd_reg;
    logic [tked_pkg::ByteWidth-1:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            byte_reg <= in_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.cmd     = cmd_reg;
    assign item.in_byte = byte_reg;

endmodule

// File: rtl/tked_decode.sv
// ----------------------------------------------------------------------------
// tked_decode: escape sequence state machine
// Decodes one item per cycle from the input register while the result register
// is free, and updates the sequence state when the item advances.
// ----------------------------------------------------------------------------
module tked_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  tked_pkg::item_t  item,
    input  logic             advance,
    output tked_pkg::result_t res
);

    tked_pkg::phase_t               phase_reg;
    tked_pkg::phase_t               phase_next;
    tked_pkg::intro_t               intro_reg;
    tked_pkg::intro_t               intro_next;
    logic [tked_pkg::KeyWidth-1:0]  tilde_reg;
    logic [tked_pkg::KeyWidth-1:0]  tilde_next;
    logic                           ctrl_reg;
    logic                           ctrl_next;
    logic [tked_pkg::ByteWidth-1:0] b;
    logic                           is_digit;

    assign b        = item.in_byte;
    assign is_digit = (b >= tked_pkg::BYTE_ZERO) && (b <= tked_pkg::BYTE_NINE);

    always_comb
    begin
        phase_next     = phase_reg;
        intro_next     = intro_reg;
        tilde_next     = tilde_reg;
        ctrl_next      = ctrl_reg;
        res.valid      = 1'b0;
        res.key        = tked_pkg::KEY_PLAIN;
        res.plain_byte = '0;

        if (item.cmd != tked_pkg::CMD_BYTE)
        begin
            phase_next = tked_pkg::PH_IDLE;
            if (phase_reg == tked_pkg::PH_ESC || phase_reg == tked_pkg::PH_INTRO ||
                phase_reg == tked_pkg::PH_DIGIT || phase_reg == tked_pkg::PH_SEMI ||
                phase_reg == tked_pkg::PH_MOD)
            begin
                res = tked_pkg::key_result(tked_pkg::KEY_ESC);
            end
            else if (item.cmd != tked_pkg::CMD_TIMEOUT)
            begin
                res = tked_pkg::key_result(tked_pkg::KEY_ERROR);
            end
        end
        else
        begin
            unique case (phase_reg)
                tked_pkg::PH_ESC:
                begin
                    if (b == tked_pkg::BYTE_CSI)
                        intro_next = tked_pkg::INTRO_CSI;
                    else if (b == tked_pkg::BYTE_SS3)
                        intro_next = tked_pkg::INTRO_SS3;
                    else
                        intro_next = tked_pkg::INTRO_OTHER;
                    phase_next = tked_pkg::PH_INTRO;
                end
                tked_pkg::PH_INTRO:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    if (intro_reg == tked_pkg::INTRO_CSI && is_digit)
                    begin
                        tilde_next = tked_pkg::tilde_key(b);
                        phase_next = tked_pkg::PH_DIGIT;
                    end
                    else if (intro_reg == tked_pkg::INTRO_CSI ||
                             intro_reg == tked_pkg::INTRO_SS3)
                    begin
                        res = tked_pkg::key_result(tked_pkg::letter_key(b));
                    end
                    else
                    begin
                        res = tked_pkg::key_result(tked_pkg::KEY_ESC);
                    end
                end
                tked_pkg::PH_DIGIT:
                begin
                    if (b == tked_pkg::BYTE_SEMI)
                    begin
                        phase_next = tked_pkg::PH_SEMI;
                    end
                    else
                    begin
                        phase_next = tked_pkg::PH_IDLE;
                        res = tked_pkg::key_result((b == tked_pkg::BYTE_TILDE) ?
                                                   tilde_reg : tked_pkg::KEY_ESC);
                    end
                end
                tked_pkg::PH_SEMI:
                begin
                    ctrl_next  = (b == tked_pkg::BYTE_CTRL);
                    phase_next = tked_pkg::PH_MOD;
                end
                tked_pkg::PH_MOD:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    if (ctrl_reg && b == tked_pkg::BYTE_H)
                        res = tked_pkg::key_result(tked_pkg::KEY_FILETOP);
                    else if (ctrl_reg && b == tked_pkg::BYTE_F)
                        res = tked_pkg::key_result(tked_pkg::KEY_FILEEND);
                    else
                        res = tked_pkg::key_result(tked_pkg::KEY_ESC);
                end
                default:
                begin
                    // idle
                    if (b == tked_pkg::BYTE_ESC)
                    begin
                        phase_next = tked_pkg::PH_ESC;
                    end
                    else
                    begin
                        phase_next     = tked_pkg::PH_IDLE;
                        res.valid      = 1'b1;
                        res.key        = tked_pkg::KEY_PLAIN;
                        res.plain_byte = b;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tked_pkg::PH_IDLE;
            intro_reg <= tked_pkg::INTRO_CSI;
            tilde_reg <= tked_pkg::KEY_ESC;
            ctrl_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            intro_reg <= intro_next;
            tilde_reg <= tilde_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    a_err_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid && res.key == tked_pkg::KEY_ERROR |-> phase_reg == tked_pkg::PH_IDLE)
        else $error("error key reported inside a sequence");

    a_event_closes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.cmd != tked_pkg::CMD_BYTE |=> phase_reg == tked_pkg::PH_IDLE)
        else $error("timeout or error left a sequence open");

    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid |=> phase_reg == tked_pkg::PH_IDLE)
        else $error("result issued without closing the sequence");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg))
        else $error("phase moved without an item");

endmodule

// File: rtl/tked_out_stage.sv
// ----------------------------------------------------------------------------
// tked_out_stage: result register
// Holds one decoded item until the consumer takes it.
// ----------------------------------------------------------------------------
module tked_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tked_pkg::result_t               res,
    input  logic                            load,
    output logic                            free,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tked_pkg::KeyWidth-1:0]   key,
    output logic [tked_pkg::ByteWidth-1:0]  plain_byte
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [tked_pkg::KeyWidth-1:0]  key_reg;
    logic [tked_pkg::ByteWidth-1:0] byte_reg;
    logic                           take;

    assign free       = !valid_reg || out_ready;
    assign take       = load && res.valid;
    assign valid_next = take || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg  <= res.key;
            byte_reg <= res.plain_byte;
        end
    end

    assign out_valid  = valid_reg;
    assign key        = key_reg;
    assign plain_byte = byte_reg;

endmodule

// File: rtl/terminal_key_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_unit: VT100/ANSI key escape sequence decoder
// Path: input register, combinational decode, then the result register.
// Throughput: 1 item per cycle; the result register stalls the input only
//   while a result waits and out_ready is low.
// Reset: rst_n asynchronous active low; empties both registers, phase idle.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tked_pkg::CmdWidth-1:0]   cmd,
    input  logic [tked_pkg::ByteWidth-1:0]  in_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tked_pkg::KeyWidth-1:0]   key,
    output logic [tked_pkg::ByteWidth-1:0]  plain_byte
);

    tked_pkg::item_t   item;
    tked_pkg::result_t res;
    logic              out_free;
    logic              advance;

    assign advance = item.valid && out_free;

    tked_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .in_byte  (in_byte),
        .advance  (advance),
        .item     (item)
    );

    tked_decode u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .res     (res)
    );

    tked_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .load       (advance),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key        (key),
        .plain_byte (plain_byte)
    );

endmodule

// File: tb/terminal_key_escape_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_unit_tb: self-checking bench for the key decoder
// Drives terminal input items (bytes, timeouts, read errors) over valid/ready,
// predicts the decoded keys in a behavioral model of the escape state machine
// and compares every result item field by field. A short directed list is
// followed by random escape sequences, broken sequences and noise, with
// random idle cycles on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_unit_tb;

    localparam logic [tked_pkg::CmdWidth-1:0] CMD_ERROR = 2'd2;
    localparam logic [tked_pkg::CmdWidth-1:0] CMD_SPARE = 2'd3;  // decodes as a read error
    localparam int NumInputs  = 750;
    localparam int IdleLimit  = 2000;
    localparam int TailCycles = 8;

    typedef struct packed {
        logic [tked_pkg::CmdWidth-1:0]  cmd;
        logic [tked_pkg::ByteWidth-1:0] data;
    } term_input_t;

    typedef struct packed {
        logic [tked_pkg::KeyWidth-1:0]  code;
        logic [tked_pkg::ByteWidth-1:0] ch;
    } key_out_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_ready;
    logic [tked_pkg::CmdWidth-1:0]  cmd        = tked_pkg::CMD_BYTE;
    logic [tked_pkg::ByteWidth-1:0] in_byte    = '0;
    logic                           out_valid;
    logic                           out_ready  = 1'b0;
    logic [tked_pkg::KeyWidth-1:0]  key;
    logic [tked_pkg::ByteWidth-1:0] plain_byte;

    term_input_t pending_inputs[$];
    key_out_t    expected_keys[$];
    term_input_t next_input;
    key_out_t    head_key;
    int          errors    = 0;
    int          idle_run  = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    int          recv_draw = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;

    // decoder model state
    tked_pkg::phase_t               seq_phase = tked_pkg::PH_IDLE;
    tked_pkg::intro_t               seq_intro = tked_pkg::INTRO_CSI;
    logic [tked_pkg::ByteWidth-1:0] seq_digit = '0;
    logic                           seq_ctrl  = 1'b0;

    terminal_key_escape_decoder_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key        (key),
        .plain_byte (plain_byte)
    );

    always #6 clk = ~clk;

    function automatic logic [tked_pkg::KeyWidth-1:0] arrow_code(
        input logic [tked_pkg::ByteWidth-1:0] b);
        unique case (b)
            tked_pkg::BYTE_A: return tked_pkg::KEY_ARROW_UP;
            tked_pkg::BYTE_B: return tked_pkg::KEY_ARROW_DN;
            tked_pkg::BYTE_C: return tked_pkg::KEY_ARROW_RT;
            tked_pkg::BYTE_D: return tked_pkg::KEY_ARROW_LT;
            tked_pkg::BYTE_H: return tked_pkg::KEY_LINE_START;
            tked_pkg::BYTE_F: return tked_pkg::KEY_LINE_END;
            default:          return tked_pkg::KEY_ESC;
        endcase
    endfunction

    function automatic logic [tked_pkg::KeyWidth-1:0] tilde_code(
        input logic [tked_pkg::ByteWidth-1:0] d);
        unique case (d)
            tked_pkg::BYTE_1, tked_pkg::BYTE_7: return tked_pkg::KEY_LINE_START;
            tked_pkg::BYTE_3:                   return tked_pkg::KEY_DEL;
            tked_pkg::BYTE_4, tked_pkg::BYTE_8: return tked_pkg::KEY_LINE_END;
            tked_pkg::BYTE_CTRL:                return tked_pkg::KEY_PAGE_UP;
            tked_pkg::BYTE_6:                   return tked_pkg::KEY_PAGE_DN;
            default:                            return tked_pkg::KEY_ESC;
        endcase
    endfunction

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    // closes the sequence with a decoded key
    task automatic finish_key(input logic [tked_pkg::KeyWidth-1:0] k);
        key_out_t r;
        r.code = k;
        r.ch   = (k == tked_pkg::KEY_ESC) ? tked_pkg::BYTE_ESC : '0;
        expected_keys.push_back(r);
        seq_phase = tked_pkg::PH_IDLE;
    endtask

    task automatic decode_input(input term_input_t t);
        key_out_t r;
        if (t.cmd != tked_pkg::CMD_BYTE)
        begin
            if (seq_phase != tked_pkg::PH_IDLE)
                finish_key(tked_pkg::KEY_ESC);
            else if (t.cmd != tked_pkg::CMD_TIMEOUT)
                finish_key(tked_pkg::KEY_ERROR);
            return;
        end
        unique case (seq_phase)
            tked_pkg::PH_IDLE:
            begin
                if (t.data == tked_pkg::BYTE_ESC)
                    seq_phase = tked_pkg::PH_ESC;
                else
                begin
                    r.code = tked_pkg::KEY_PLAIN;
                    r.ch   = t.data;
                    expected_keys.push_back(r);
                end
            end
            tked_pkg::PH_ESC:
            begin
                seq_intro = (t.data == tked_pkg::BYTE_CSI) ? tked_pkg::INTRO_CSI :
                            (t.data == tked_pkg::BYTE_SS3) ? tked_pkg::INTRO_SS3 :
                                                             tked_pkg::INTRO_OTHER;
                seq_phase = tked_pkg::PH_INTRO;
            end
            tked_pkg::PH_INTRO:
            begin
                if (seq_intro == tked_pkg::INTRO_CSI && t.data >= tked_pkg::BYTE_ZERO &&
                    t.data <= tked_pkg::BYTE_NINE)
                begin
                    seq_digit = t.data;
                    seq_phase = tked_pkg::PH_DIGIT;
                end
                else if (seq_intro == tked_pkg::INTRO_OTHER)
                    finish_key(tked_pkg::KEY_ESC);
                else
                    finish_key(arrow_code(t.data));
            end
            tked_pkg::PH_DIGIT:
            begin
                if (t.data == tked_pkg::BYTE_TILDE)
                    finish_key(tilde_code(seq_digit));
                else if (t.data == tked_pkg::BYTE_SEMI)
                    seq_phase = tked_pkg::PH_SEMI;
                else
                    finish_key(tked_pkg::KEY_ESC);
            end
            tked_pkg::PH_SEMI:
            begin
                seq_ctrl  = (t.data == tked_pkg::BYTE_CTRL);
                seq_phase = tked_pkg::PH_MOD;
            end
            default:
            begin
                if (seq_ctrl && t.data == tked_pkg::BYTE_H)
                    finish_key(tked_pkg::KEY_FILETOP);
                else if (seq_ctrl && t.data == tked_pkg::BYTE_F)
                    finish_key(tked_pkg::KEY_FILEEND);
                else
                    finish_key(tked_pkg::KEY_ESC);
            end
        endcase
    endtask

    task automatic add_input(input logic [tked_pkg::CmdWidth-1:0] c,
                             input logic [tked_pkg::ByteWidth-1:0] d);
        term_input_t t;
        t.cmd  = c;
        t.data = d;
        pending_inputs.push_back(t);
    endtask

    task automatic add_bytes(input logic [tked_pkg::ByteWidth-1:0] b0,
                             input logic [tked_pkg::ByteWidth-1:0] b1,
                             input logic [tked_pkg::ByteWidth-1:0] b2);
        add_input(tked_pkg::CMD_BYTE, b0);
        add_input(tked_pkg::CMD_BYTE, b1);
        add_input(tked_pkg::CMD_BYTE, b2);
    endtask

    function automatic logic [tked_pkg::ByteWidth-1:0] rand_byte();
        return tked_pkg::ByteWidth'($urandom_range(0, 255));
    endfunction

    function automatic logic [tked_pkg::ByteWidth-1:0] rand_final();
        case ($urandom_range(0, 7))
            0:       return tked_pkg::BYTE_A;
            1:       return tked_pkg::BYTE_B;
            2:       return tked_pkg::BYTE_C;
            3:       return tked_pkg::BYTE_D;
            4:       return tked_pkg::BYTE_H;
            5:       return tked_pkg::BYTE_F;
            default: return rand_byte();
        endcase
    endfunction

    function automatic logic [tked_pkg::ByteWidth-1:0] rand_digit();
        return tked_pkg::BYTE_ZERO + tked_pkg::ByteWidth'($urandom_range(0, 9));
    endfunction

    function automatic logic [tked_pkg::CmdWidth-1:0] rand_break();
        return tked_pkg::CmdWidth'($urandom_range(1, 3));
    endfunction

    // stimulus
    initial
    begin
        int pick;
        int n;
        logic [tked_pkg::ByteWidth-1:0] prefix [5];

        // directed
        add_input(tked_pkg::CMD_BYTE, 8'h00);
        add_input(tked_pkg::CMD_BYTE, 8'hff);
        add_input(tked_pkg::CMD_TIMEOUT, 8'ha5);
        add_input(CMD_ERROR, 8'h5a);
        add_input(CMD_SPARE, 8'hff);
        add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_CSI, tked_pkg::BYTE_A);
        add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_SS3, tked_pkg::BYTE_F);
        add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_CSI, tked_pkg::BYTE_CTRL);
        add_input(tked_pkg::CMD_BYTE, tked_pkg::BYTE_TILDE);
        add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_CSI, tked_pkg::BYTE_1);
        add_bytes(tked_pkg::BYTE_SEMI, tked_pkg::BYTE_CTRL, tked_pkg::BYTE_H);
        add_input(tked_pkg::CMD_BYTE, tked_pkg::BYTE_ESC);
        add_input(tked_pkg::CMD_TIMEOUT, 8'h00);
        add_bytes(tked_pkg::BYTE_ESC, 8'h58, 8'h5a);     // other introducer
        add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_CSI, tked_pkg::BYTE_ESC); // ESC as final

        // random sequences
        while (pending_inputs.size() < NumInputs)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                add_input(tked_pkg::CMD_BYTE, rand_byte());
            else if (pick < 35)
                add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_CSI, rand_final());
            else if (pick < 45)
                add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_SS3, rand_final());
            else if (pick < 65)
            begin
                add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_CSI, rand_digit());
                add_input(tked_pkg::CMD_BYTE,
                          ($urandom_range(0, 4) != 0) ? tked_pkg::BYTE_TILDE : rand_byte());
            end
            else if (pick < 80)
            begin
                add_bytes(tked_pkg::BYTE_ESC, tked_pkg::BYTE_CSI, rand_digit());
                add_bytes(($urandom_range(0, 5) != 0) ? tked_pkg::BYTE_SEMI : rand_byte(),
                          ($urandom_range(0, 3) != 0) ? tked_pkg::BYTE_CTRL : rand_byte(),
                          rand_final());
            end
            else if (pick < 88)
                add_bytes(tked_pkg::BYTE_ESC, rand_byte(), rand_byte());
            else if (pick < 95)
            begin
                prefix[0] = tked_pkg::BYTE_ESC;
                prefix[1] = ($urandom_range(0, 3) != 0) ? tked_pkg::BYTE_CSI :
                                                          tked_pkg::BYTE_SS3;
                prefix[2] = rand_digit();
                prefix[3] = tked_pkg::BYTE_SEMI;
                prefix[4] = tked_pkg::BYTE_CTRL;
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    add_input(tked_pkg::CMD_BYTE, prefix[i]);
                add_input(rand_break(), rand_byte());
            end
            else
                add_input(rand_break(), rand_byte());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_inputs.size() != 0 || in_valid || expected_keys.size() != 0);
        repeat (TailCycles) @(negedge clk);

        if (errors == 0)
            $display("terminal_key_escape_decoder_unit_tb: done, clean");
        else
            $display("terminal_key_escape_decoder_unit_tb: done, errors");
        $finish;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cmd       <= tked_pkg::CMD_BYTE;
            in_byte   <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_input(term_input_t'{cmd: cmd, data: in_byte});
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end
                else if (pending_inputs.size() > 0)
                begin
                    next_input = pending_inputs.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= next_input.cmd;
                    in_byte   <= next_input.data;
                    send_wait <= draw_wait(send_steady);
                    if ($urandom_range(0, 39) == 0)
                        send_steady <= ~send_steady;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_keys.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual key %0d byte %0h",
                             $time, key, plain_byte);
                end
                else
                begin
                    head_key = expected_keys.pop_front();
                    if (key !== head_key.code)
                    begin
                        errors++;
                        $display("%0t: key mismatch: expected %0d, actual %0d",
                                 $time, head_key.code, key);
                    end
                    if (plain_byte !== head_key.ch)
                    begin
                        errors++;
                        $display("%0t: plain_byte mismatch: expected %0h, actual %0h",
                                 $time, head_key.ch, plain_byte);
                    end
                end
                recv_draw = draw_wait(recv_steady);
                recv_wait <= recv_draw;
                out_ready <= (recv_draw == 0);
                if ($urandom_range(0, 39) == 0)
                    recv_steady <= ~recv_steady;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                out_ready <= (recv_wait == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run <= 0;
            else if (idle_run + 1 >= IdleLimit)
            begin
                $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
                $display("terminal_key_escape_decoder_unit_tb: done, errors");
                $finish;
            end
            else
                idle_run <= idle_run + 1;
        end
    end

endmodule
